@@ sv/rrf_pkg.sv @@
// ----------------------------------------------------------------------------
// rrf_pkg: shared types and constants for the reply framer
// Byte codes, reply kinds, parser state encodings and the result record.
// ----------------------------------------------------------------------------
package rrf_pkg;

	localparam int unsigned CountW = 32;
	localparam int unsigned RemW   = 33;
	localparam int unsigned TotalW = 34;

	localparam logic [CountW-1:0] CountMax = '1;

	localparam logic [7:0] ChCr    = 8'h0d;
	localparam logic [7:0] ChLf    = 8'h0a;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChPlus  = 8'h2b;
	localparam logic [7:0] ChMinus = 8'h2d;
	localparam logic [7:0] ChColon = 8'h3a;
	localparam logic [7:0] ChStar  = 8'h2a;
	localparam logic [7:0] ChDollar = 8'h24;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;

	typedef enum logic [2:0] {
		KIND_STATUS     = 3'd0,
		KIND_ERROR      = 3'd1,
		KIND_INTEGER    = 3'd2,
		KIND_BULK       = 3'd3,
		KIND_NULL_BULK  = 3'd4,
		KIND_MULTIBULK  = 3'd5,
		KIND_UNKNOWN    = 3'd6,
		KIND_BAD_LENGTH = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		PH_LINE = 2'b01,
		PH_BULK = 2'b10
	} phase_t;

	typedef enum logic [3:0] {
		ST_SKIP   = 4'b0001,
		ST_SIGN   = 4'b0010,
		ST_DIGITS = 4'b0100,
		ST_DONE   = 4'b1000
	} lstage_t;

	typedef struct packed {
		kind_t              kind;
		logic               err_flag;
		logic               hit;
		logic [TotalW-1:0]  byte_total;
	} result_t;

endpackage

@@ sv/rrf_parser.sv @@
// ----------------------------------------------------------------------------
// rrf_parser: per-byte framing state and result generation
// Holds the line/bulk state and produces at most one result per byte.
// ----------------------------------------------------------------------------
module rrf_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_in,
	output logic             res_valid,
	output rrf_pkg::result_t res
);
	import rrf_pkg::*;

	phase_t            phase_q, n_phase;
	logic              pending_cr_q, n_pending_cr;
	logic [CountW-1:0] line_count_q, n_line_count;
	logic [7:0]        type_q, n_type;
	lstage_t           stage_q, n_stage;
	logic              neg_q, n_neg;
	logic [CountW-1:0] len_q, n_len;
	logic [RemW-1:0]   remain_q, n_remain;
	logic [CountW-1:0] blen_q, n_blen;

	logic              is_digit;
	logic [CountW+3:0] len_x10;
	logic [CountW-1:0] len_sat;
	logic [CountW-1:0] lc_inc;

	assign is_digit = (byte_in >= ChZero) && (byte_in <= ChNine);
	// len*10 + digit as shift-and-add
	assign len_x10  = {1'b0, len_q, 3'b000} + {3'b000, len_q, 1'b0}
		+ {{CountW{1'b0}}, byte_in[3:0]};
	assign len_sat  = (len_x10[CountW+3:CountW] != 4'd0) ? CountMax : len_x10[CountW-1:0];
	assign lc_inc   = (line_count_q == CountMax) ? line_count_q : line_count_q + CountW'(1);

	always_comb begin
		n_phase      = phase_q;
		n_pending_cr = pending_cr_q;
		n_line_count = line_count_q;
		n_type       = type_q;
		n_stage      = stage_q;
		n_neg        = neg_q;
		n_len        = len_q;
		n_remain     = remain_q;
		n_blen       = blen_q;
		res_valid    = 1'b0;
		res          = '0;

		unique case (phase_q)
			PH_BULK: begin
				if (remain_q <= RemW'(1)) begin
					res_valid      = 1'b1;
					res.kind       = KIND_BULK;
					res.hit        = (blen_q != '0);
					res.byte_total = {2'b00, line_count_q} + {2'b00, blen_q} + TotalW'(2);
					n_phase        = PH_LINE;
					n_pending_cr   = 1'b0;
					n_line_count   = '0;
					n_type         = '0;
					n_stage        = ST_SKIP;
					n_neg          = 1'b0;
					n_len          = '0;
					n_remain       = '0;
				end else begin
					n_remain = remain_q - RemW'(1);
				end
			end
			PH_LINE: begin
				if (line_count_q == '0) begin
					n_type = byte_in;
				end else if (stage_q == ST_SKIP && byte_in == ChSpace) begin
					n_stage = ST_SKIP;
				end else if (stage_q == ST_SKIP && (byte_in == ChPlus || byte_in == ChMinus)) begin
					n_neg   = (byte_in == ChMinus);
					n_stage = ST_SIGN;
				end else if (stage_q != ST_DONE) begin
					if (!is_digit) begin
						n_stage = ST_DONE;
					end else begin
						n_stage = ST_DIGITS;
						n_len   = len_sat;
					end
				end
				n_line_count = lc_inc;

				if (!(pending_cr_q && byte_in == ChLf)) begin
					n_pending_cr = (byte_in == ChCr);
				end else begin
					n_pending_cr   = 1'b0;
					res_valid      = 1'b1;
					res.byte_total = {2'b00, n_line_count};
					if (n_line_count == CountW'(2)) begin
						res.kind     = KIND_UNKNOWN;
						res.err_flag = 1'b1;
					end else begin
						unique case (n_type)
							ChPlus:  res.kind = KIND_STATUS;
							ChMinus: begin
								res.kind     = KIND_ERROR;
								res.err_flag = 1'b1;
							end
							ChColon: res.kind = KIND_INTEGER;
							ChStar:  begin
								res.kind     = KIND_MULTIBULK;
								res.err_flag = 1'b1;
							end
							ChDollar: begin
								if (n_neg && n_len == CountW'(1)) begin
									res.kind = KIND_NULL_BULK;
								end else if (n_neg && n_len != '0) begin
									res.kind     = KIND_BAD_LENGTH;
									res.err_flag = 1'b1;
								end else begin
									// enter the bulk body; line state is kept for the total
									res_valid = 1'b0;
									n_blen    = n_len;
									n_remain  = {1'b0, n_len} + RemW'(2);
									n_phase   = PH_BULK;
								end
							end
							default: begin
								res.kind     = KIND_UNKNOWN;
								res.err_flag = 1'b1;
							end
						endcase
					end
					if (res_valid) begin
						n_phase      = PH_LINE;
						n_line_count = '0;
						n_type       = '0;
						n_stage      = ST_SKIP;
						n_neg        = 1'b0;
						n_len        = '0;
					end
				end
			end
			default: begin
				n_phase = PH_LINE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LINE;
			pending_cr_q <= 1'b0;
			line_count_q <= '0;
			type_q       <= '0;
			stage_q      <= ST_SKIP;
			neg_q        <= 1'b0;
			len_q        <= '0;
			remain_q     <= '0;
			blen_q       <= '0;
		end else if (step) begin
			phase_q      <= n_phase;
			pending_cr_q <= n_pending_cr;
			line_count_q <= n_line_count;
			type_q       <= n_type;
			stage_q      <= n_stage;
			neg_q        <= n_neg;
			len_q        <= n_len;
			remain_q     <= n_remain;
			blen_q       <= n_blen;
		end
	end

endmodule

@@ sv/resp_reply_framer.sv @@
// ----------------------------------------------------------------------------
// resp_reply_framer: frames serialization-protocol replies from a byte stream
// Registered byte in, one parse step, registered reply record out.
// ----------------------------------------------------------------------------
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  rx      | rx_valid, rx_ready, rx_byte[7:0]              | in
//  reply   | reply_valid, reply_ready, reply_kind[2:0],    | out
//          | err_flag, hit, byte_total[33:0]               |
//
// One byte per cycle sustained while replies are taken. A byte is registered on
// acceptance and parsed once the output slot is free; any resulting reply is
// registered in the output register, which drives reply_valid.
// Reset clears all framing state and empties both registers. A stalled reply
// holds the parse step; the input register then fills and rx_ready drops
// until the reply is taken.
//
module resp_reply_framer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rx_valid,
	output logic                       rx_ready,
	input  logic [7:0]                 rx_byte,
	output logic                       reply_valid,
	input  logic                       reply_ready,
	output rrf_pkg::kind_t             reply_kind,
	output logic                       err_flag,
	output logic                       hit,
	output logic [rrf_pkg::TotalW-1:0] byte_total
);
	import rrf_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       adv_s1;
	logic       out_free;
	logic       p_valid;
	result_t    p_res;
	logic       res_vld_s2;
	result_t    res_s2;

	// output slot is free when empty or being drained this cycle
	assign out_free = !res_vld_s2 || reply_ready;
	assign adv_s1   = vld_s1 && out_free;
	assign rx_ready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx_ready) begin
			vld_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	rrf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.byte_in   (byte_s1),
		.res_valid (p_valid),
		.res       (p_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s2 <= 1'b0;
		end else if (out_free) begin
			res_vld_s2 <= adv_s1 && p_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && p_valid) begin
			res_s2 <= p_res;
		end
	end

	assign reply_valid = res_vld_s2;
	assign reply_kind  = res_s2.kind;
	assign err_flag    = res_s2.err_flag;
	assign hit         = res_s2.hit;
	assign byte_total  = res_s2.byte_total;

endmodule

@@ sv/rrf_checker.sv @@
// ----------------------------------------------------------------------------
// rrf_checker: port-level checks for the reply framer
// Reply handshake rules and consistency of the reply record fields.
// ----------------------------------------------------------------------------
module rrf_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       reply_valid,
	input logic                       reply_ready,
	input rrf_pkg::kind_t             reply_kind,
	input logic                       err_flag,
	input logic                       hit,
	input logic [rrf_pkg::TotalW-1:0] byte_total
);
	import rrf_pkg::*;

	a_reply_hold: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && !reply_ready |=> reply_valid)
		else $error("reply dropped while stalled");

	a_reply_stable: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && !reply_ready |=> $stable(reply_kind) && $stable(byte_total)
			&& $stable(err_flag) && $stable(hit))
		else $error("reply payload changed while stalled");

	a_error_flag: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid |-> err_flag == (reply_kind == KIND_ERROR
			|| reply_kind == KIND_MULTIBULK || reply_kind == KIND_UNKNOWN
			|| reply_kind == KIND_BAD_LENGTH))
		else $error("error flag disagrees with reply kind");

	// a hit needs at least a one-digit header line and one data byte plus CRLF
	a_hit_bulk: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && hit |-> reply_kind == KIND_BULK && byte_total >= TotalW'(7))
		else $error("hit on a non-bulk or undersized reply");

endmodule

bind resp_reply_framer rrf_checker u_rrf_checker (.*);

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for resp_reply_framer
// Drives reply bytes through the rx channel and checks each framed reply
// against a cycle-free predictor of the framing rules. Both channels idle
// and stall in random bursts except in the closing back-to-back phase.
// ----------------------------------------------------------------------------
module tb_top;

	import rrf_pkg::*;

	// DUT ports
	logic              clk;
	logic              arst_n;
	logic              rx_valid;
	logic              rx_ready;
	logic [7:0]        rx_byte;
	logic              reply_valid;
	logic              reply_ready;
	kind_t             reply_kind;
	logic              err_flag;
	logic              hit;
	logic [TotalW-1:0] byte_total;

	resp_reply_framer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_ready   (rx_ready),
		.rx_byte    (rx_byte),
		.reply_valid(reply_valid),
		.reply_ready(reply_ready),
		.reply_kind (reply_kind),
		.err_flag   (err_flag),
		.hit        (hit),
		.byte_total (byte_total)
	);

	// 100 MHz
	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: mirrors the framer's line/bulk tracking.
	// ------------------------------------------------------------------
	logic              in_bulk;     // skipping bulk payload
	logic              cr_seen;     // previous line byte was CR
	logic [CountW-1:0] line_bytes;  // bytes of current line, CRLF included
	logic [7:0]        lead_byte;   // type byte of current line
	lstage_t           len_stage;
	logic              len_neg;
	logic [CountW-1:0] len_mag;     // saturating length magnitude
	logic [RemW-1:0]   skip_left;   // payload bytes left, trailer included
	logic [CountW-1:0] bulk_len;

	result_t expected_replies[$];
	result_t head_reply;

	// Bookkeeping
	int   error_count;
	int   bytes_sent;
	int   replies_predicted;
	int   replies_seen;
	logic [7:0] kinds_seen;
	logic idle_en;              // random bursts on both channels

	logic [7:0] pkt[$];         // byte image of the next reply to send

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		error_count++;
	endtask

	task automatic push_reply(input kind_t k, input logic err, input logic h,
			input logic [TotalW-1:0] span);
		result_t r;
		r.kind       = k;
		r.err_flag   = err;
		r.hit        = h;
		r.byte_total = span;
		expected_replies.push_back(r);
		replies_predicted++;
	endtask

	task automatic open_line();
		in_bulk    = 1'b0;
		cr_seen    = 1'b0;
		line_bytes = '0;
		lead_byte  = '0;
		len_stage  = ST_SKIP;
		len_neg    = 1'b0;
		len_mag    = '0;
	endtask

	// Length field of a '$' line: spaces, optional sign, digits until the
	// first non-digit; the rest of the line is ignored.
	task automatic length_digit(input logic [7:0] b);
		logic [35:0] acc;
		if (len_stage == ST_SKIP) begin
			if (b == ChSpace)
				return;
			if (b == ChPlus || b == ChMinus) begin
				len_neg   = (b == ChMinus);
				len_stage = ST_SIGN;
				return;
			end
		end
		if (len_stage == ST_DONE)
			return;
		if (b < ChZero || b > ChNine) begin
			len_stage = ST_DONE;
			return;
		end
		len_stage = ST_DIGITS;
		acc = 36'(len_mag) * 10 + 36'(b - ChZero);
		len_mag = (acc > 36'(CountMax)) ? CountMax : acc[31:0];
	endtask

	// Advance the predictor by one accepted byte; queue a reply if one ends.
	task automatic track_byte(input logic [7:0] b);
		logic [TotalW-1:0] span;
		if (in_bulk) begin
			if (skip_left <= RemW'(1)) begin
				span = TotalW'(line_bytes) + TotalW'(bulk_len) + TotalW'(2);
				push_reply(KIND_BULK, 1'b0, bulk_len != '0, span);
				open_line();
				skip_left = '0;
			end else begin
				skip_left = skip_left - RemW'(1);
			end
			return;
		end
		if (line_bytes == '0)
			lead_byte = b;
		else
			length_digit(b);
		if (line_bytes != CountMax)
			line_bytes++;
		if (!(cr_seen && b == ChLf)) begin
			cr_seen = (b == ChCr);
			return;
		end
		// CRLF closes the line
		cr_seen = 1'b0;
		span = TotalW'(line_bytes);
		if (line_bytes == CountW'(2)) begin
			// bare CRLF: no type byte at all
			push_reply(KIND_UNKNOWN, 1'b1, 1'b0, span);
		end else begin
			case (lead_byte)
				ChPlus:  push_reply(KIND_STATUS, 1'b0, 1'b0, span);
				ChMinus: push_reply(KIND_ERROR, 1'b1, 1'b0, span);
				ChColon: push_reply(KIND_INTEGER, 1'b0, 1'b0, span);
				ChStar:  push_reply(KIND_MULTIBULK, 1'b1, 1'b0, span);
				ChDollar: begin
					if (len_neg && len_mag == CountW'(1)) begin
						push_reply(KIND_NULL_BULK, 1'b0, 1'b0, span);
					end else if (len_neg && len_mag != '0) begin
						push_reply(KIND_BAD_LENGTH, 1'b1, 1'b0, span);
					end else begin
						// payload plus trailer skipped; line count kept for total
						bulk_len  = len_mag;
						skip_left = RemW'(len_mag) + RemW'(2);
						in_bulk   = 1'b1;
						return;
					end
				end
				default: push_reply(KIND_UNKNOWN, 1'b1, 1'b0, span);
			endcase
		end
		open_line();
	endtask

	// ------------------------------------------------------------------
	// rx driver. Called right after a rising edge; returns right after the
	// edge that accepted the byte, with rx_valid still high.
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!rx_ready) @(posedge clk);
		track_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_line(input string s);
		send_text(s);
		send_byte(ChCr);
		send_byte(ChLf);
	endtask

	task automatic send_pkt();
		foreach (pkt[i])
			send_byte(pkt[i]);
	endtask

	// Drop valid and hold off until every predicted reply has been taken.
	task automatic wait_drained(input int guard_cycles);
		int guard;
		rx_valid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (expected_replies.size() != 0 && guard < guard_cycles) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// ------------------------------------------------------------------
	// Reply builders for the random part
	// ------------------------------------------------------------------
	function automatic void push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			pkt.push_back(s[i]);
	endfunction

	function automatic void push_crlf();
		pkt.push_back(ChCr);
		pkt.push_back(ChLf);
	endfunction

	// Free text, heavy on lone CR/LF but never a CR directly followed by LF
	function automatic void push_text(input int n);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			c = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 7) == 0)
				c = $urandom_range(0, 1) ? ChCr : ChLf;
			if (pkt.size() != 0 && pkt[$] == ChCr && c == ChLf)
				c = "a";
			pkt.push_back(c);
		end
	endfunction

	function automatic void push_spaces();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) pkt.push_back(ChSpace);
	endfunction

	// One well-formed reply with random content into pkt
	function automatic void build_reply();
		int sel;
		int len;
		logic [7:0] t;
		pkt.delete();
		sel = $urandom_range(0, 99);
		if (sel < 15) begin
			pkt.push_back(ChPlus);
			push_text($urandom_range(0, 8));
			push_crlf();
		end else if (sel < 25) begin
			pkt.push_back(ChMinus);
			push_text($urandom_range(0, 12));
			push_crlf();
		end else if (sel < 35) begin
			pkt.push_back(ChColon);
			if ($urandom_range(0, 1))
				pkt.push_back(ChMinus);
			push_str($sformatf("%0d", $urandom_range(0, 999999)));
			push_crlf();
		end else if (sel < 70) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300)
				: $urandom_range(0, 16);
			pkt.push_back(ChDollar);
			push_spaces();
			if ($urandom_range(0, 7) == 0)
				pkt.push_back(ChPlus);
			if ($urandom_range(0, 7) == 0)
				pkt.push_back(ChZero);
			push_str($sformatf("%0d", len));
			if ($urandom_range(0, 7) == 0) begin
				// trailing junk must not start with a digit
				pkt.push_back(";");
				push_text($urandom_range(0, 3));
			end
			push_crlf();
			repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 9) == 0)
				repeat (2) pkt.push_back(8'($urandom_range(0, 255)));
			else
				push_crlf();
		end else if (sel < 78) begin
			pkt.push_back(ChDollar);
			push_spaces();
			pkt.push_back(ChMinus);
			repeat ($urandom_range(0, 2)) pkt.push_back(ChZero);
			pkt.push_back("1");
			if ($urandom_range(0, 3) == 0) begin
				pkt.push_back("x");
				push_text($urandom_range(0, 3));
			end
			push_crlf();
		end else if (sel < 86) begin
			pkt.push_back(ChDollar);
			push_spaces();
			pkt.push_back(ChMinus);
			if ($urandom_range(0, 3) == 0) begin
				// far past 32 bits: magnitude saturates
				pkt.push_back("9");
				repeat (10) pkt.push_back(8'(ChZero + $urandom_range(0, 9)));
			end else begin
				push_str($sformatf("%0d", $urandom_range(2, 999999)));
			end
			push_crlf();
		end else if (sel < 91) begin
			pkt.push_back(ChStar);
			push_str($sformatf("%0d", $urandom_range(0, 99)));
			push_crlf();
		end else if (sel < 96) begin
			do
				t = 8'($urandom_range(0, 255));
			while (t == ChPlus || t == ChMinus || t == ChColon || t == ChStar
				|| t == ChDollar);
			pkt.push_back(t);
			push_text($urandom_range(0, 6));
			push_crlf();
		end else begin
			push_crlf();
		end
	endfunction

	// ------------------------------------------------------------------
	// Reply sink: random stall bursts while idle_en is set.
	// ------------------------------------------------------------------
	initial begin
		reply_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (idle_en && $urandom_range(0, 5) == 0) begin
				reply_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			reply_ready <= 1'b1;
		end
	end

	// Reply checker: every accepted reply against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && reply_valid && reply_ready) begin
			replies_seen++;
			kinds_seen[reply_kind] = 1'b1;
			if (expected_replies.size() == 0) begin
				report_mismatch($sformatf("unexpected reply kind %0d len %0d",
					reply_kind, byte_total));
			end else begin
				head_reply = expected_replies.pop_front();
				if (reply_kind !== head_reply.kind)
					report_mismatch($sformatf("reply_kind got %0d want %0d",
						reply_kind, head_reply.kind));
				if (err_flag !== head_reply.err_flag)
					report_mismatch($sformatf("err_flag got %0b want %0b (kind %0d)",
						err_flag, head_reply.err_flag, head_reply.kind));
				if (hit !== head_reply.hit)
					report_mismatch($sformatf("hit got %0b want %0b (kind %0d)",
						hit, head_reply.hit, head_reply.kind));
				if (byte_total !== head_reply.byte_total)
					report_mismatch($sformatf("byte_total got %0d want %0d (kind %0d)",
						byte_total, head_reply.byte_total, head_reply.kind));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Single-line replies, empty line, lone CR/LF, extreme byte values
	task automatic test_line_replies();
		send_line("+OK");
		send_line("-ERR unknown command");
		send_line(":-42");
		send_line("+");
		send_line("*2");
		send_line("!x");
		send_line("");
		// lone CR and lone LF stay inside the line
		send_text("+a");
		send_byte(ChCr);
		send_text("b");
		send_byte(ChLf);
		send_line("c");
		// CR CR LF: only the last pair ends the line
		send_text("+x");
		send_byte(ChCr);
		send_line("");
		send_byte(8'h00);
		send_byte(8'hff);
		send_line("");
		send_byte(8'hff);
		send_line("");
	endtask

	// Bulk replies, length syntax variants, payload never inspected
	task automatic test_bulk_lengths();
		send_line("$0");
		send_line("");
		send_line("$3");
		send_line("abc");
		send_line("$+2");
		send_line("xy");
		send_line("$  4 tail");
		send_line("wxyz");
		send_line("$-");       // sign only: length 0
		send_line("");
		send_line("$-0");
		send_line("");
		send_line("$");        // no digits: length 0
		send_line("");
		send_line("$x5");      // digits after a non-digit are ignored
		send_line("");
		send_line("$--1");     // second sign ends the number at 0
		send_line("");
		send_line("$007");
		send_line("1234567");
		send_line("$2");       // payload is itself a CRLF
		send_line("");
		send_line("");
		send_line("$1");       // trailer need not be CRLF
		send_text("qzz");
		send_line("$64");
		repeat (64) send_byte(8'($urandom_range(0, 255)));
		send_line("");
	endtask

	// Null bulk and rejected negative lengths, including saturation, then a +1 bulk
	task automatic test_length_errors();
		send_line("$-1");
		send_line("$ -1junk");
		send_line("$-01");
		send_line("$-2");
		send_line("$-4294967295");
		send_line("$-4294967296");
		send_line("$-99999999999");
		send_line("$ +1");
		send_line("z");
	endtask

	// Bursts of replies with the sender held off until all are drained
	task automatic test_drain_pause();
		repeat (2) begin
			repeat ($urandom_range(2, 5)) begin
				build_reply();
				send_pkt();
			end
			wait_drained(20000);
		end
	endtask

	// Mostly well-formed replies; some noise and truncated replies
	task automatic test_random_replies(input int n_bytes, input int n_replies);
		int first_byte;
		int first_reply;
		int keep;
		first_byte  = bytes_sent;
		first_reply = replies_predicted;
		while (bytes_sent - first_byte < n_bytes
				|| replies_predicted - first_reply < n_replies) begin
			if ($urandom_range(0, 99) < 85) begin
				build_reply();
			end else if ($urandom_range(0, 1)) begin
				pkt.delete();
				push_text($urandom_range(1, 2));
			end else begin
				build_reply();
				keep = $urandom_range(1, pkt.size() - 1);
				while (pkt.size() > keep) void'(pkt.pop_back());
			end
			send_pkt();
		end
	endtask

	// Full rate on both channels: no gaps, no stalls
	task automatic test_back_to_back();
		idle_en  = 1'b0;
		rx_valid <= 1'b0;
		repeat (2) @(posedge clk);
		test_random_replies(60, 5);
	endtask

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		rx_valid    = 1'b0;
		rx_byte     = '0;
		idle_en     = 1'b1;
		error_count = 0;
		bytes_sent  = 0;
		replies_predicted = 0;
		replies_seen = 0;
		kinds_seen  = '0;
		open_line();
		skip_left   = '0;
		bulk_len    = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_line_replies();
		test_bulk_lengths();
		test_length_errors();
		test_drain_pause();
		test_random_replies(100, 8);
		test_back_to_back();

		// let the last replies drain through the input and output registers
		wait_drained(20000);
		repeat (8) @(posedge clk);
		if (expected_replies.size() != 0)
			report_mismatch($sformatf("%0d predicted replies never arrived",
				expected_replies.size()));

		$display("Sent %0d bytes; %0d replies framed and checked.",
			bytes_sent, replies_seen);
		$display("Reply kinds observed (bit per kind): %08b", kinds_seen);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("Timeout waiting for handshakes");
		$display("Test completed with failures");
		$finish;
	end

endmodule
